/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/spr_pkg.sv */
// Package with the types and constants of the sparse point range sum block.
`default_nettype none

package spr_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned ENTRY_W = COORD_W + VALUE_W;

  // Operation codes of an input transaction; code 3 is accepted and ignored.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } spr_state_t;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [COORD_W-1:0]  point_coord;
    logic signed [VALUE_W-1:0]  point_value;
    logic signed [COORD_W-1:0]  query_low;
    logic signed [COORD_W-1:0]  query_high;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    range_sum;
    logic                       points_dropped;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;
    logic clr;
    logic qry;
    logic rd;
    logic load_out;
  } spr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
    logic out_free;
  } spr_sts_t;

endpackage

`default_nettype wire

/* hdl/spr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module spr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/spr_ctrl.sv */
// Controller state machine of the sparse point range sum block.
`default_nettype none

module spr_ctrl
  import spr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic [1:0] in_opcode,
  output logic          in_ready,
  input  wire spr_sts_t sts,
  output spr_cmd_t      cmd
);

  spr_state_t state_r, state_nxt;
  logic       accept;
  logic       is_add, is_qry, is_clr;

  // Opcode decode.
  always_comb begin
    is_add = 1'b0;
    is_qry = 1'b0;
    is_clr = 1'b0;
    unique case (in_opcode)
      OP_ADD:   is_add = 1'b1;
      OP_QUERY: is_qry = 1'b1;
      OP_CLEAR: is_clr = 1'b1;
      default:  ;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_qry) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_end && !sts.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.add = accept && is_add;
        cmd.clr = accept && is_clr;
        cmd.qry = accept && is_qry;
      end
      ST_SCAN: begin
        cmd.rd = !sts.scan_end;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/spr_dp.sv */
// Datapath: point store, scan pipeline, accumulator and result register.
`default_nettype none

module spr_dp
  import spr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_t      in_data,
  input  wire spr_cmd_t cmd,
  output spr_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_t          out_data
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_POINTS);

  logic [CW-1:0]             count_r, idx_r;
  logic                      overflow_r;
  logic                      full;
  logic                      ram_we;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic signed [COORD_W-1:0] lo_r, hi_r;
  logic                      neg_r;
  logic                      rd_v1_r, v2_r;
  logic signed [COORD_W-1:0] rd_coord;
  logic signed [VALUE_W-1:0] rd_value;
  logic                      hit;
  logic signed [VALUE_W-1:0] hit_r;
  logic [SUM_W-1:0]          acc_r, acc_nxt;
  logic [SUM_W-1:0]          sum_final;
  logic                      out_valid_r;
  out_t                      out_data_r;

  assign full   = (count_r == FULL_COUNT);
  assign ram_we = cmd.add && !full;

  // Point store: coordinate in the upper half, value in the lower half.
  spr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata({in_data.point_coord, in_data.point_value}),
    .re   (cmd.rd),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Fill count and drop flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (cmd.clr) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (cmd.add) begin
      if (full) begin
        overflow_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Query bounds and the scan index.
  always_ff @(posedge clk) begin
    if (cmd.qry) begin
      lo_r  <= in_data.query_low;
      hi_r  <= in_data.query_high;
      neg_r <= (in_data.query_low > in_data.query_high);
      idx_r <= '0;
    end else if (cmd.rd) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // Range test on the entry read in the previous cycle.
  assign rd_coord = ram_rdata[ENTRY_W-1:VALUE_W];
  assign rd_value = ram_rdata[VALUE_W-1:0];

  always_comb begin
    if (neg_r) begin
      hit = (rd_coord > hi_r) && (rd_coord < lo_r);
    end else begin
      hit = (rd_coord >= lo_r) && (rd_coord <= hi_r);
    end
  end

  // Pipeline valid flags of the read and compare stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v1_r <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      rd_v1_r <= cmd.rd;
      v2_r    <= rd_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit ? rd_value : '0;
  end

  // Accumulate the masked values, modulo 2^48.
  assign acc_nxt = acc_r + {{(SUM_W-VALUE_W){hit_r[VALUE_W-1]}}, hit_r};

  always_ff @(posedge clk) begin
    if (cmd.qry) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  // A reversed query returns minus the strict in-between sum.
  assign sum_final = neg_r ? (SUM_W'(0) - acc_r) : acc_r;

  // Result register that holds a transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.range_sum      <= sum_final;
      out_data_r.points_dropped <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.scan_end  = (idx_r == count_r);
  assign sts.pipe_busy = rd_v1_r || v2_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

/* hdl/sparse_point_range_sum.sv */
// Top level of the sparse point range sum block.
//
// Input transactions arrive on in_valid/in_ready/in_data. Opcode add appends
// a point to the store (dropped and flagged once MAX_POINTS are held), clear
// empties the store and the drop flag, query returns one result transaction
// on out_valid/out_ready/out_data, and opcode 3 is taken and ignored.
// Adds and clears can follow one another every cycle while no query is in
// progress. A query scans the store one point per cycle through the single
// read port of the point memory; the next transaction is taken once
// the result is in the output register. A result that the receiver stalls
// stays in that register, and adds and clears are still taken meanwhile; a
// following query scans but waits at its end until the register is free.
// Reset (rst_n low, synchronous) empties the store, clears the drop flag and
// any pending result; no clearing pass over the memory is needed.
`default_nettype none

module sparse_point_range_sum
  import spr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  spr_cmd_t cmd;
  spr_sts_t sts;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_data.opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spr_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* hdl/spr_chk.sv */
// Port-level checker of the sparse point range sum block and its bind.
`default_nettype none
`include "assert_macros.svh"

module spr_chk
  import spr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A stalled result transaction stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Reset leaves no result pending and the input side open.
  `ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_valid && in_ready, "bad state after reset")

  // A query occupies the block for at least the next cycle.
  `ASSERT_CLK(a_query_busy, clk, rst_n, in_valid && in_ready && in_data.opcode == OP_QUERY |=> !in_ready, "input taken during a query scan")

  // Adds and clears never block the next transaction.
  `ASSERT_CLK(a_add_clear_open, clk, rst_n, in_valid && in_ready && (in_data.opcode == OP_ADD || in_data.opcode == OP_CLEAR) |=> in_ready, "input stalled after add or clear")

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")

endmodule

bind sparse_point_range_sum spr_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire

/* dv/tb_sparse_point_range_sum.sv */
// Self-checking testbench for the sparse point range sum block.
`timescale 1ns / 100ps

module tb_sparse_point_range_sum;
  import spr_pkg::*;

  localparam int unsigned CAPACITY      = 1024;
  localparam int          RANDOM_ITEMS  = 80;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // Shadow copy of the point store, updated on every accepted transaction.
  logic signed [COORD_W-1:0] store_coord [CAPACITY];
  logic signed [VALUE_W-1:0] store_value [CAPACITY];
  int unsigned               store_count    = 0;
  logic                      store_overflow = 1'b0;

  // Results still owed by the block, oldest first.
  out_t pending_sums[$];

  int   mismatch_count  = 0;
  int   items_taken     = 0;
  int   queries_checked = 0;
  int   adds_dropped    = 0;
  int   peak_store      = 0;
  bit   tx_steady       = 1'b0;
  bit   rx_steady       = 1'b0;
  int   rx_stall_left   = 0;
  logic signed [COORD_W-1:0] coord_base = '0;

  sparse_point_range_sum #(
    .MAX_POINTS(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle(bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Sum of the values stored in lo..hi, or minus the sum strictly between
  // hi and lo when the bounds are reversed.
  function automatic logic signed [SUM_W-1:0] range_sum_of(
    logic signed [COORD_W-1:0] lo,
    logic signed [COORD_W-1:0] hi
  );
    logic signed [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < store_count; i++) begin
      if (lo <= hi) begin
        if (store_coord[i] >= lo && store_coord[i] <= hi) begin
          acc = acc + store_value[i];
        end
      end else if (store_coord[i] > hi && store_coord[i] < lo) begin
        acc = acc - store_value[i];
      end
    end
    return acc;
  endfunction

  // Apply one accepted transaction to the shadow store.
  function automatic void track_transaction(in_t item);
    out_t sum;
    case (item.opcode)
      OP_ADD: begin
        if (store_count < CAPACITY) begin
          store_coord[store_count] = item.point_coord;
          store_value[store_count] = item.point_value;
          store_count++;
          if (store_count > peak_store) begin
            peak_store = store_count;
          end
        end else begin
          store_overflow = 1'b1;
          adds_dropped++;
        end
      end
      OP_CLEAR: begin
        store_count    = 0;
        store_overflow = 1'b0;
      end
      OP_QUERY: begin
        sum.range_sum      = range_sum_of(item.query_low, item.query_high);
        sum.points_dropped = store_overflow;
        pending_sums.insert(pending_sums.size(), sum);
      end
      default: begin
      end
    endcase
  endfunction

  // Transaction with the given opcode and random content in every field.
  function automatic in_t make_item(logic [1:0] opc);
    in_t item;
    item.opcode      = opc;
    item.point_coord = $urandom;
    item.point_value = $urandom;
    item.query_low   = $urandom;
    item.query_high  = $urandom;
    return item;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int roll;
    int offset;
    roll   = $urandom_range(0, 99);
    offset = int'($urandom_range(0, 16)) - 8;
    if (roll < 6) begin
      return COORD_MIN;
    end
    if (roll < 12) begin
      return COORD_MAX;
    end
    if (roll < 22) begin
      return $urandom;
    end
    return coord_base + offset;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return VALUE_MIN;
    end
    if (roll < 20) begin
      return VALUE_MAX;
    end
    return $urandom;
  endfunction

  // Query bound near stored points, near the current cluster, or anywhere.
  function automatic logic signed [COORD_W-1:0] pick_bound();
    int roll;
    int offset;
    roll   = $urandom_range(0, 99);
    offset = int'($urandom_range(0, 4)) - 2;
    if (roll < 40 && store_count > 0) begin
      return store_coord[$urandom_range(0, store_count - 1)] + offset;
    end
    if (roll < 48) begin
      return COORD_MIN;
    end
    if (roll < 56) begin
      return COORD_MAX;
    end
    if (roll < 70) begin
      return $urandom;
    end
    offset = int'($urandom_range(0, 24)) - 12;
    return coord_base + offset;
  endfunction

  // Send one transaction; entered and left at a falling edge, valid left high.
  task automatic send_item(in_t item);
    int idle;
    idle = pick_idle(tx_steady);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    track_transaction(item);
    if (item.opcode != OP_UNUSED) begin
      items_taken++;
    end
    @(negedge clk);
  endtask

  task automatic send_add(logic signed [COORD_W-1:0] coord, logic signed [VALUE_W-1:0] value);
    in_t item;
    item             = make_item(OP_ADD);
    item.point_coord = coord;
    item.point_value = value;
    send_item(item);
  endtask

  task automatic send_query(logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi);
    in_t item;
    item            = make_item(OP_QUERY);
    item.query_low  = lo;
    item.query_high = hi;
    send_item(item);
  endtask

  task automatic send_clear();
    send_item(make_item(OP_CLEAR));
  endtask

  task automatic send_unused();
    send_item(make_item(OP_UNUSED));
  endtask

  // Stop sending until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_sums.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Queries, clears and ignored codes against an empty store.
  task automatic test_empty_store();
    send_query(COORD_MIN, COORD_MAX);
    send_query(32'sd5, 32'sd3);
    send_clear();
    send_unused();
    send_query(32'sd0, 32'sd0);
    wait_drained();
  endtask

  // Extreme coordinates and values, shared coordinates and reversed bounds.
  task automatic test_point_ranges();
    send_add(COORD_MIN, VALUE_MIN);
    send_add(COORD_MAX, VALUE_MAX);
    send_add(32'sd0, -32'sd1);
    send_add(32'sd0, 32'sd5);
    send_add(-32'sd1, 32'sd7);
    send_unused();
    send_add(32'sd1, VALUE_MIN);
    send_query(COORD_MIN, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, COORD_MAX);
    send_query(32'sd0, 32'sd0);
    // Low one above high: an empty reversed range.
    send_query(32'sd1, 32'sd0);
    send_query(COORD_MAX, COORD_MIN);
    send_query(32'sd1, -32'sd1);
    send_query(-32'sd1, 32'sd1);
    send_clear();
    send_query(COORD_MIN, COORD_MAX);
    wait_drained();
  endtask

  // Fill the store, query it full, overflow it, then clear the drop flag.
  task automatic test_store_capacity();
    tx_steady  = 1'b1;
    coord_base = $urandom;
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0:       send_add(COORD_MIN, VALUE_MIN);
        1:       send_add(COORD_MAX, VALUE_MAX);
        default: send_add(pick_coord(), pick_value());
      endcase
    end
    tx_steady = 1'b0;
    send_query(COORD_MIN, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, COORD_MAX);
    send_query(COORD_MAX, COORD_MIN);
    send_query(pick_bound(), pick_bound());
    // Adds into a full store are dropped and raise the flag.
    repeat (3) send_add(pick_coord(), pick_value());
    send_query(COORD_MIN, COORD_MAX);
    send_unused();
    send_query(COORD_MIN, COORD_MIN);
    send_clear();
    send_add(32'sd0, 32'sd1);
    send_query(32'sd0, 32'sd0);
    send_clear();
    wait_drained();
  endtask

  // Random mix: mostly build-and-query sequences, some noise and pauses.
  task automatic test_random_traffic();
    int start;
    int roll;
    int len;
    int kind;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic signed [COORD_W-1:0] swap;
    start = items_taken;
    while (items_taken - start < RANDOM_ITEMS) begin
      roll       = $urandom_range(0, 99);
      tx_steady  = ($urandom_range(0, 99) < 20);
      rx_steady  = ($urandom_range(0, 99) < 20);
      coord_base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 64)) - 32 : $urandom;
      if (roll < 75) begin
        if (store_count > 64 || $urandom_range(0, 1) == 1) begin
          send_clear();
        end
        len = $urandom_range(4, 24);
        repeat (len) begin
          kind = $urandom_range(0, 99);
          if (kind < 55) begin
            send_add(pick_coord(), pick_value());
          end else if (kind < 96) begin
            lo   = pick_bound();
            hi   = pick_bound();
            kind = $urandom_range(0, 99);
            if ((kind < 25) ? (lo < hi) : (lo > hi)) begin
              swap = lo;
              lo   = hi;
              hi   = swap;
            end
            if (kind >= 25 && kind < 30) begin
              lo = hi + 1;
            end
            send_query(lo, hi);
          end else begin
            send_unused();
          end
        end
      end else if (roll < 95) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(make_item(2'($urandom_range(0, 3))));
      end else begin
        wait_drained();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: random back-pressure with steady stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 25) begin
        rx_stall_left = pick_idle(1'b0);
      end
    end
  end

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: result with none owed, expected nothing, actual sum %0d dropped %0b",
                 $time, out_data.range_sum, out_data.points_dropped);
        mismatch_count++;
      end else begin
        want = pending_sums.pop_front();
        queries_checked++;
        if (out_data.range_sum !== want.range_sum) begin
          $display("%0t: range_sum differs, expected %0d actual %0d",
                   $time, want.range_sum, out_data.range_sum);
          mismatch_count++;
        end
        if (out_data.points_dropped !== want.points_dropped) begin
          $display("%0t: points_dropped differs, expected %0b actual %0b",
                   $time, want.points_dropped, out_data.points_dropped);
          mismatch_count++;
        end
      end
    end
  end

  // Hard limit on run time.
  initial begin
    #100ms;
    $display("Timed out with %0d results still owed", pending_sums.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_point_ranges();
    test_store_capacity();
    test_random_traffic();
    wait_drained();
    // Room for any stray result from a late scan.
    repeat (CAPACITY + 16) @(negedge clk);
    $display("Covered %0d transactions and %0d query results, %0d adds beyond capacity.",
             items_taken, queries_checked, adds_dropped);
    $display("Largest store held %0d points.", peak_store);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
